FILE: src/fbc_pkg.sv
// shared constants and types for the frustum box cull block
package fbc_pkg;

  // planes tested per box (1..8); slots past the register file read as zero
  localparam int unsigned PLANE_COUNT    = 6;
  localparam int unsigned NUM_PLANE_REGS = 6;

  // apb geometry: 64-bit registers at 8-byte strides
  localparam int unsigned PDATA_W = 64;
  localparam int unsigned PADDR_W = 6;
  localparam int unsigned REG_IDX_LSB = 3;
  localparam int unsigned REG_IDX_W   = PADDR_W - REG_IDX_LSB;

  // datapath widths
  localparam int unsigned COORD_W = 16;
  localparam int unsigned PROD_W  = 2 * COORD_W;
  localparam int unsigned FRAC_W  = 14;
  localparam int unsigned DIST_W  = PROD_W + 2;

  // register stages from input transfer to result register
  localparam int unsigned PIPE_DEPTH = 4;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vec3_t;

  // a in the low bits, d in the high bits
  typedef struct packed {
    coord_t d;
    coord_t c;
    coord_t b;
    coord_t a;
  } plane_t;

endpackage

FILE: src/fbc_if.sv
// valid/ready channel interfaces for boxes in and cull results out
interface fbc_box_if;
  logic   valid;
  logic   ready;
  fbc_pkg::coord_t lo_x;
  fbc_pkg::coord_t lo_y;
  fbc_pkg::coord_t lo_z;
  fbc_pkg::coord_t hi_x;
  fbc_pkg::coord_t hi_y;
  fbc_pkg::coord_t hi_z;

  modport source (output valid, output lo_x, output lo_y, output lo_z,
                  output hi_x, output hi_y, output hi_z, input ready);
  modport sink   (input valid, input lo_x, input lo_y, input lo_z,
                  input hi_x, input hi_y, input hi_z, output ready);
endinterface

interface fbc_res_if;
  logic valid;
  logic ready;
  logic visible;
  logic box_invalid;

  modport source (output valid, output visible, output box_invalid, input ready);
  modport sink   (input valid, input visible, input box_invalid, output ready);
endinterface

FILE: src/fbc_lane.sv
// one plane lane: positive vertex select, multiply, sum and sign test
module fbc_lane (
  input  logic                clk_i,
  input  logic                en_i,
  input  fbc_pkg::plane_t     plane_i,
  input  fbc_pkg::vec3_t      lo_i,
  input  fbc_pkg::vec3_t      hi_i,
  output logic                cull_o
);

  // stage 1: positive vertex and coefficients
  fbc_pkg::vec3_t  vtx_d, vtx_q;
  fbc_pkg::plane_t pl_q;

  // stage 2: products and plane offset
  logic signed [fbc_pkg::PROD_W-1:0] pa_d, pb_d, pc_d;
  logic signed [fbc_pkg::PROD_W-1:0] pa_q, pb_q, pc_q;
  fbc_pkg::coord_t                   pd_q;

  // stage 3: sign of the distance
  logic signed [fbc_pkg::DIST_W-1:0] dist_sum;
  logic                              cull_q;

  always_comb begin
    vtx_d.x = plane_i.a[fbc_pkg::COORD_W-1] ? lo_i.x : hi_i.x;
    vtx_d.y = plane_i.b[fbc_pkg::COORD_W-1] ? lo_i.y : hi_i.y;
    vtx_d.z = plane_i.c[fbc_pkg::COORD_W-1] ? lo_i.z : hi_i.z;
  end

  assign pa_d = pl_q.a * vtx_q.x;
  assign pb_d = pl_q.b * vtx_q.y;
  assign pc_d = pl_q.c * vtx_q.z;

  // exact distance at 2^-14 scale, never overflows 34 bits
  assign dist_sum = {{2{pa_q[fbc_pkg::PROD_W-1]}}, pa_q}
                  + {{2{pb_q[fbc_pkg::PROD_W-1]}}, pb_q}
                  + {{2{pc_q[fbc_pkg::PROD_W-1]}}, pc_q}
                  + {{(fbc_pkg::DIST_W-fbc_pkg::COORD_W-fbc_pkg::FRAC_W){pd_q[fbc_pkg::COORD_W-1]}},
                     pd_q, {fbc_pkg::FRAC_W{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vtx_q  <= vtx_d;
      pl_q   <= plane_i;
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      pc_q   <= pc_d;
      pd_q   <= pl_q.d;
      cull_q <= dist_sum[fbc_pkg::DIST_W-1];
    end
  end

  assign cull_o = cull_q;

endmodule

FILE: src/frustum_box_cull_top.sv
// frustum box cull: tests axis-aligned boxes against configured planes
// Accepts one box per clock while the result side keeps ready high and
// returns one result per box, in the order the boxes came in.
// The pipeline is four register stages: positive vertex select, one 16x16
// multiply per axis per plane, the 34-bit distance sum and sign, then the
// result register; the multiplier stage sets the clock. All stages move
// together when the result register is empty or being taken, so a stall
// holds every item in place. A box with any min above its max gives
// box_invalid=1 and visible=0. Planes are written over apb, 64 bits each at
// byte address 8*i: a in bits 15:0, b 31:16, c 47:32 (Q1.14), d 63:48
// (world units). Write planes only while no box is in flight.
module frustum_box_cull_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // apb configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbc_pkg::PADDR_W-1:0]   paddr,
  input  logic [fbc_pkg::PDATA_W-1:0]   pwdata,
  output logic [fbc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // box and result channels
  fbc_box_if.sink                       box_i,
  fbc_res_if.source                     res_o
);

  // plane register file
  logic [fbc_pkg::PDATA_W-1:0]   plane_q [fbc_pkg::NUM_PLANE_REGS];
  logic [fbc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          reg_hit;
  logic                          cfg_wr;

  // pipeline control
  logic                          advance;
  logic                          in_xfer;
  logic                          v1_q, v2_q, v3_q;
  logic                          inv1_q, inv2_q, inv3_q;
  logic                          box_bad;

  // result register
  logic                          out_v_q;
  logic                          vis_d, vis_q;
  logic                          inv_out_q;

  fbc_pkg::vec3_t                lo, hi;
  fbc_pkg::plane_t               plane_w [fbc_pkg::PLANE_COUNT];
  logic [fbc_pkg::PLANE_COUNT-1:0] cull;

  // ---------------------------------------------------------------- apb
  assign pready  = 1'b1;
  assign reg_idx = paddr[fbc_pkg::PADDR_W-1:fbc_pkg::REG_IDX_LSB];
  assign reg_hit = reg_idx < fbc_pkg::REG_IDX_W'(fbc_pkg::NUM_PLANE_REGS);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  // unused index codes read as zero
  assign prdata  = reg_hit ? plane_q[reg_idx] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fbc_pkg::NUM_PLANE_REGS; i++) begin
        plane_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      plane_q[reg_idx] <= pwdata;
    end
  end

  // plane slots beyond the register file are all zero and never cull
  for (genvar p = 0; p < fbc_pkg::PLANE_COUNT; p++) begin : g_plane
    if (p < fbc_pkg::NUM_PLANE_REGS) begin : g_reg
      assign plane_w[p] = fbc_pkg::plane_t'(plane_q[p]);
    end else begin : g_zero
      assign plane_w[p] = '0;
    end
  end

  // ---------------------------------------------------------------- pipeline
  // every stage steps when the result register is free or being drained
  assign advance     = !out_v_q || res_o.ready;
  assign box_i.ready = advance;
  assign in_xfer     = box_i.valid && advance;

  assign lo.x = box_i.lo_x;
  assign lo.y = box_i.lo_y;
  assign lo.z = box_i.lo_z;
  assign hi.x = box_i.hi_x;
  assign hi.y = box_i.hi_y;
  assign hi.z = box_i.hi_z;

  // degenerate boxes (min equal to max) stay valid
  assign box_bad = (lo.x > hi.x) || (lo.y > hi.y) || (lo.z > hi.z);

  for (genvar p = 0; p < fbc_pkg::PLANE_COUNT; p++) begin : g_lane
    fbc_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (advance),
      .plane_i (plane_w[p]),
      .lo_i    (lo),
      .hi_i    (hi),
      .cull_o  (cull[p])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (advance) begin
      v1_q    <= in_xfer;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      out_v_q <= v3_q;
    end
  end

  // invalid boxes skip the plane test outcome
  assign vis_d = !inv3_q && !(|cull);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      inv1_q    <= box_bad;
      inv2_q    <= inv1_q;
      inv3_q    <= inv2_q;
      vis_q     <= vis_d;
      inv_out_q <= inv3_q;
    end
  end

  assign res_o.valid       = out_v_q;
  assign res_o.visible     = vis_q;
  assign res_o.box_invalid = inv_out_q;

endmodule

FILE: src/fbc_checker.sv
// port-level checks for the frustum box cull block, bound to the top level
module fbc_checker (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  logic visible_i,
  input  logic box_invalid_i
);

  logic       in_xfer, out_xfer;
  logic [2:0] cnt_d, cnt_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // boxes accepted whose result has not been transferred yet
  assign cnt_d = cnt_q + 3'(in_xfer) - 3'(out_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // a result only ever follows an accepted box
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> cnt_q != 3'd0)
    else $error("result transfer with no box in flight");

  // no more boxes in flight than pipeline stages
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(fbc_pkg::PIPE_DEPTH))
    else $error("more boxes in flight than pipeline stages");

  // an invalid box is never reported visible
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && box_invalid_i |-> !visible_i)
    else $error("invalid box reported visible");

  // with the result side ready throughout, an accepted box reaches the output with no stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("result missing after pipeline latency");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(visible_i) && $stable(box_invalid_i))
    else $error("stalled result changed");

endmodule

bind frustum_box_cull_top fbc_checker u_fbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (box_i.valid),
  .in_ready_i    (box_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .visible_i     (res_o.visible),
  .box_invalid_i (res_o.box_invalid)
);

FILE: tb/sv/tb_top.sv
// testbench for frustum_box_cull_top: directed table, then random plane sets and box streams
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PLANE_SLOTS     = 8;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int NUM_PHASES      = 8;
  localparam int HOLD_CYCLES     = 40;
  localparam int MAX_GAP         = 14;
  localparam int STALL_LIMIT     = 2000;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    fbc_pkg::vec3_t lo;
    fbc_pkg::vec3_t hi;
  } box_t;

  typedef struct packed {
    logic visible;
    logic box_invalid;
  } cull_res_t;

  typedef enum logic {ROW_BOX, ROW_PLANE} row_kind_e;

  typedef enum logic [1:0] {PL_FRUSTUM, PL_RANDOM, PL_SPARSE, PL_EXTREME} plane_style_e;

  // one line of the directed table: either a box transfer or a plane write
  typedef struct {
    row_kind_e   kind;
    box_t        bx;
    bit          typed;
    cull_res_t   res;
    int          idx;
    logic [63:0] val;
  } dir_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [fbc_pkg::PADDR_W-1:0] paddr;
  logic [fbc_pkg::PDATA_W-1:0] pwdata;
  logic [fbc_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  fbc_box_if box_ch ();
  fbc_res_if res_ch ();

  frustum_box_cull_top dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .box_i   (box_ch),
    .res_o   (res_ch)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the plane registers; slots past the register file stay zero
  fbc_pkg::plane_t plane_shadow [PLANE_SLOTS];
  cull_res_t       expected_culls [$];
  int              err_count;
  int              res_count;
  bit              src_idle;
  bit              sink_idle;
  bit              hold_req;

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // expected cull verdict for one box against the shadow planes
  function automatic cull_res_t predict_cull(input box_t bx);
    cull_res_t       r;
    fbc_pkg::plane_t pl;
    longint          acc;
    fbc_pkg::coord_t n;
    fbc_pkg::coord_t lo_c;
    fbc_pkg::coord_t hi_c;
    r.visible     = 1'b1;
    r.box_invalid = 1'b0;
    for (int k = 0; k < 3; k++) begin
      lo_c = bx.lo[16*k +: 16];
      hi_c = bx.hi[16*k +: 16];
      if (lo_c > hi_c) r.box_invalid = 1'b1;
    end
    if (r.box_invalid) begin
      r.visible = 1'b0;
    end else begin
      for (int i = 0; i < fbc_pkg::PLANE_COUNT && i < PLANE_SLOTS; i++) begin
        pl  = plane_shadow[i];
        // d scaled up to the Q1.14 product scale
        acc = longint'(pl.d) * 16384;
        for (int k = 0; k < 3; k++) begin
          n    = pl[16*k +: 16];
          lo_c = bx.lo[16*k +: 16];
          hi_c = bx.hi[16*k +: 16];
          // positive vertex: min where the normal points negative
          acc += longint'(n) * longint'((n < 0) ? lo_c : hi_c);
        end
        if (acc < 0) r.visible = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic dir_row_t box_row(input int lx, input int ly, input int lz,
                                       input int hx, input int hy, input int hz,
                                       input bit typed = 1'b0, input bit vis = 1'b0,
                                       input bit inv = 1'b0);
    dir_row_t r;
    r.kind            = ROW_BOX;
    r.bx.lo.x         = fbc_pkg::coord_t'(lx);
    r.bx.lo.y         = fbc_pkg::coord_t'(ly);
    r.bx.lo.z         = fbc_pkg::coord_t'(lz);
    r.bx.hi.x         = fbc_pkg::coord_t'(hx);
    r.bx.hi.y         = fbc_pkg::coord_t'(hy);
    r.bx.hi.z         = fbc_pkg::coord_t'(hz);
    r.typed           = typed;
    r.res.visible     = vis;
    r.res.box_invalid = inv;
    r.idx             = 0;
    r.val             = '0;
    return r;
  endfunction

  function automatic dir_row_t plane_row(input int idx, input logic [63:0] val);
    dir_row_t r;
    r       = box_row(0, 0, 0, 0, 0, 0);
    r.kind  = ROW_PLANE;
    r.idx   = idx;
    r.val   = val;
    return r;
  endfunction

  // plane sets: a box-shaped frustum with slight tilt, raw bits, raw bits with about half the planes zero, extremes
  function automatic logic [63:0] make_plane(input plane_style_e style, input int idx);
    fbc_pkg::plane_t pl;
    int              comp [3];
    case (style)
      PL_FRUSTUM: begin
        for (int k = 0; k < 3; k++) comp[k] = int'($urandom_range(0, 2048)) - 1024;
        comp[(idx / 2) % 3] = (idx % 2 == 0) ? 16384 : -16384;
        pl.a = fbc_pkg::coord_t'(comp[0]);
        pl.b = fbc_pkg::coord_t'(comp[1]);
        pl.c = fbc_pkg::coord_t'(comp[2]);
        pl.d = fbc_pkg::coord_t'($urandom_range(0, 20000));
      end
      PL_RANDOM: pl = {$urandom, $urandom};
      PL_SPARSE: pl = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
      default: begin
        case ($urandom_range(0, 5))
          0:       pl = 64'h0000_0000_0000_0000;
          1:       pl = 64'hFFFF_FFFF_FFFF_FFFF;
          2:       pl = 64'h7FFF_7FFF_7FFF_7FFF;
          3:       pl = 64'h8000_8000_8000_8000;
          4:       pl = 64'h8000_7FFF_8000_7FFF;
          default: pl = 64'h7FFF_8000_7FFF_8000;
        endcase
      end
    endcase
    return pl;
  endfunction

  // mostly well-formed boxes around the frustum, some raw and some inside-out
  function automatic box_t make_box();
    box_t     bx;
    int       lo [3];
    int       hi [3];
    int       pick;
    int       u;
    int       v;
    int       c;
    int       h;
    logic [2:0] flip;
    pick = $urandom_range(0, 99);
    flip = 3'($urandom_range(1, 7));
    for (int k = 0; k < 3; k++) begin
      if (pick < 15) begin
        lo[k] = int'(fbc_pkg::coord_t'($urandom));
        hi[k] = int'(fbc_pkg::coord_t'($urandom));
      end else if (pick < 27) begin
        u = int'(fbc_pkg::coord_t'($urandom));
        v = int'(fbc_pkg::coord_t'($urandom));
        if (u == v) v = (u == 32767) ? u - 1 : u + 1;
        if (flip[k]) begin
          lo[k] = (u > v) ? u : v;
          hi[k] = (u > v) ? v : u;
        end else begin
          lo[k] = (u > v) ? v : u;
          hi[k] = (u > v) ? u : v;
        end
      end else begin
        c     = int'($urandom_range(0, 60000)) - 30000;
        h     = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(0, 4000));
        lo[k] = (c - h < -32768) ? -32768 : c - h;
        hi[k] = (c + h > 32767) ? 32767 : c + h;
      end
      bx.lo[16*k +: 16] = fbc_pkg::coord_t'(lo[k]);
      bx.hi[16*k +: 16] = fbc_pkg::coord_t'(hi[k]);
    end
    return bx;
  endfunction

  // all tasks below start and end just after a falling edge
  task automatic send_box(input box_t bx);
    int gap;
    gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      box_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    box_ch.valid <= 1'b1;
    box_ch.lo_x  <= bx.lo.x;
    box_ch.lo_y  <= bx.lo.y;
    box_ch.lo_z  <= bx.lo.z;
    box_ch.hi_x  <= bx.hi.x;
    box_ch.hi_y  <= bx.hi.y;
    box_ch.hi_z  <= bx.hi.z;
    do @(posedge clk); while (!(box_ch.valid && box_ch.ready));
    @(negedge clk);
  endtask

  task automatic drain_culls();
    box_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_culls.size() != 0) @(negedge clk);
  endtask

  // apb write, then read back when the index maps to a register
  task automatic write_plane(input int idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= fbc_pkg::PADDR_W'(idx << fbc_pkg::REG_IDX_LSB);
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    if (idx < fbc_pkg::NUM_PLANE_REGS) begin
      plane_shadow[idx] = val;
      psel <= 1'b1;
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      if (prdata !== val)
        flag_error($sformatf("plane %0d readback: expected %h, got %h", idx, val, prdata));
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clk);
    end
  endtask

  // result side: per-result ready gaps, plus a long hold-off when asked
  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        for (int held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
    end
  end

  // compare each result transfer with the oldest pending verdict
  always @(posedge clk) begin : check_results
    cull_res_t want;
    if (res_ch.valid && res_ch.ready) begin
      res_count++;
      if (expected_culls.size() == 0) begin
        flag_error($sformatf("result %0d with no box pending: visible=%b box_invalid=%b",
                             res_count, res_ch.visible, res_ch.box_invalid));
      end else begin
        want = expected_culls.pop_front();
        if (res_ch.visible !== want.visible)
          flag_error($sformatf("result %0d visible: expected %b, got %b",
                               res_count, want.visible, res_ch.visible));
        if (res_ch.box_invalid !== want.box_invalid)
          flag_error($sformatf("result %0d box_invalid: expected %b, got %b",
                               res_count, want.box_invalid, res_ch.box_invalid));
      end
    end
  end

  // watchdog on cycles with no transfer and no register access
  always @(posedge clk) begin : watchdog
    int stall_cycles;
    if ((box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t dir_tab [$];
    box_t     bx;
    box_ch.valid <= 1'b0;
    box_ch.lo_x  <= '0;
    box_ch.lo_y  <= '0;
    box_ch.lo_z  <= '0;
    box_ch.hi_x  <= '0;
    box_ch.hi_y  <= '0;
    box_ch.hi_z  <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    src_idle     = 1'b1;
    sink_idle    = 1'b1;
    hold_req     = 1'b0;
    err_count    = 0;
    res_count    = 0;
    for (int i = 0; i < PLANE_SLOTS; i++) plane_shadow[i] = '0;

    // planes all zero after reset: every valid box is visible
    dir_tab.push_back(box_row(0, 0, 0, 0, 0, 0, 1, 1, 0));
    dir_tab.push_back(box_row(-32768, -32768, -32768, 32767, 32767, 32767, 1, 1, 0));
    dir_tab.push_back(box_row(32767, 32767, 32767, 32767, 32767, 32767, 1, 1, 0));
    dir_tab.push_back(box_row(-32768, -32768, -32768, -32768, -32768, -32768, 1, 1, 0));
    // inside-out boxes on each axis
    dir_tab.push_back(box_row(32767, 0, 0, -32768, 0, 0, 1, 0, 1));
    dir_tab.push_back(box_row(0, 1, 0, 0, 0, 0, 1, 0, 1));
    dir_tab.push_back(box_row(0, 0, -7, 0, 0, -8, 1, 0, 1));
    dir_tab.push_back(box_row(1, 1, 1, 0, 0, 0, 1, 0, 1));
    // flat box, min equal to max in x
    dir_tab.push_back(box_row(5, -300, -32768, 5, 300, 32767, 1, 1, 0));
    // plane x >= 100: distance exactly zero keeps the box, one unit less culls it
    dir_tab.push_back(plane_row(0, 64'hFF9C_0000_0000_4000));
    dir_tab.push_back(box_row(-5, 0, 0, 100, 0, 0, 1, 1, 0));
    dir_tab.push_back(box_row(-5, 0, 0, 99, 0, 0, 1, 0, 0));
    dir_tab.push_back(box_row(200, 0, 0, 100, 0, 0, 1, 0, 1));
    // write past the register file has no effect
    dir_tab.push_back(plane_row(6, 64'hFFFF_FFFF_FFFF_FFFF));
    dir_tab.push_back(box_row(-5, 0, 0, 100, 0, 0, 1, 1, 0));
    // extreme coefficients, checked by the predictor
    dir_tab.push_back(plane_row(1, 64'h7FFF_8000_7FFF_8000));
    dir_tab.push_back(plane_row(2, 64'h8000_7FFF_8000_7FFF));
    dir_tab.push_back(box_row(-32768, -32768, -32768, 32767, 32767, 32767));
    dir_tab.push_back(box_row(32767, 32767, 32767, 32767, 32767, 32767));
    dir_tab.push_back(box_row(-32768, -32768, -32768, -32768, -32768, -32768));
    dir_tab.push_back(plane_row(3, 64'hFFFF_FFFF_FFFF_FFFF));
    dir_tab.push_back(plane_row(4, 64'h0001_0001_0001_0001));
    dir_tab.push_back(plane_row(5, 64'h7FFF_7FFF_7FFF_7FFF));
    dir_tab.push_back(plane_row(7, 64'h8000_0000_0000_0000));
    dir_tab.push_back(box_row(0, 0, 0, 32767, 32767, 32767));
    dir_tab.push_back(box_row(-32768, -32768, -32768, 0, 0, 0));
    dir_tab.push_back(box_row(-1, -1, -1, 1, 1, 1));

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_PLANE) begin
        drain_culls();
        write_plane(dir_tab[r].idx, dir_tab[r].val);
      end else begin
        send_box(dir_tab[r].bx);
        expected_culls.push_back(dir_tab[r].typed ? dir_tab[r].res
                                                  : predict_cull(dir_tab[r].bx));
      end
    end

    // random phases, each with a fresh plane set
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_culls();
      src_idle  = (ph % 3 != 0);
      sink_idle = (ph % 4 != 1);
      for (int i = 0; i < fbc_pkg::NUM_PLANE_REGS; i++)
        write_plane(i, make_plane(plane_style_e'(ph % 4), i));
      write_plane(fbc_pkg::NUM_PLANE_REGS + ph % 2, {$urandom, $urandom});
      // result side holds off while boxes keep coming, so the pipe backs up
      if (ph == 2 || ph == 6) begin
        hold_req = 1'b1;
        src_idle = 1'b0;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // in phase 3, the sender waits for every pending result mid-phase
        if (ph == 3 && n == ITEMS_PER_PHASE / 2) drain_culls();
        bx = make_box();
        send_box(bx);
        expected_culls.push_back(predict_cull(bx));
      end
    end

    drain_culls();
    repeat (fbc_pkg::PIPE_DEPTH + 4) @(negedge clk);
    if (expected_culls.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_culls.size()));
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/fbc_pkg.sv
src/fbc_if.sv
src/fbc_lane.sv
src/frustum_box_cull_top.sv
src/fbc_checker.sv
tb/sv/tb_top.sv
